FILE: hw/rtl/quintic_trajectory_sampler_assert.svh
// Assertion macros for the quintic trajectory sampler.
// Included by the top level; no other dependencies.
`ifndef QUINTIC_TRAJECTORY_SAMPLER_ASSERT_SVH
`define QUINTIC_TRAJECTORY_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define QTS_ASSERT_IMPL(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("qts assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is high.
`define QTS_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("qts assertion failed: next-cycle implication");
`else
`define QTS_ASSERT_IMPL(name, ck, rs, ante, cons)
`define QTS_ASSERT_NEXT(name, ck, rs, ante, cons)
`endif
`endif

FILE: hw/rtl/qts_pkg.sv
// Shared types and constants of the quintic trajectory sampler.
// No dependencies.
`timescale 1ns / 1ps
package qts_pkg;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 24;
  localparam int IDX_W  = 6;
  localparam int ACC_W  = 40;
  localparam int FRAC_W = 24;
  localparam int SQ_W   = FRAC_W + 1;
  localparam int NSTEP  = 5;
  localparam int DIV_LAT = 3;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_START_VEL_X = 2'd0,
    REG_END_VEL_X   = 2'd1,
    REG_START_VEL_Y = 2'd2,
    REG_END_VEL_Y   = 2'd3
  } cfg_reg_t;

  // Nonzero polynomial and derivative coefficients of one axis.
  typedef struct packed {
    logic signed [ACC_W-1:0] c0;
    logic signed [ACC_W-1:0] c1;
    logic signed [ACC_W-1:0] c3;
    logic signed [ACC_W-1:0] c4;
    logic signed [ACC_W-1:0] c5;
    logic signed [ACC_W-1:0] d2;
    logic signed [ACC_W-1:0] d3;
    logic signed [ACC_W-1:0] d4;
  } axis_coef_t;

  typedef struct packed {
    axis_coef_t x;
    axis_coef_t y;
  } coef_set_t;

endpackage

FILE: hw/rtl/qts_front.sv
// Front end: configuration registers, item acceptance and coefficient solve.
// Depends on qts_pkg.
`timescale 1ns / 1ps
module qts_front import qts_pkg::*; #(
  parameter int DURATION_MS = 3000
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_index,
  input  logic [IN_W-1:0]         cfg_data,
  input  logic                    start,
  input  logic signed [IN_W-1:0]  start_x,
  input  logic signed [IN_W-1:0]  start_y,
  input  logic signed [IN_W-1:0]  end_x,
  input  logic signed [IN_W-1:0]  end_y,
  input  logic                    q_full,
  output logic                    busy,
  output logic                    push,
  output coef_set_t               push_data
);

  localparam logic signed [ACC_W-1:0] DUR = ACC_W'(DURATION_MS);

  logic signed [IN_W-1:0] start_vel_x;
  logic signed [IN_W-1:0] end_vel_x;
  logic signed [IN_W-1:0] start_vel_y;
  logic signed [IN_W-1:0] end_vel_y;

  // Closed-form quintic solve with zero boundary accelerations.
  function automatic axis_coef_t solve_axis(logic signed [IN_W-1:0] p0,
                                            logic signed [IN_W-1:0] p1,
                                            logic signed [IN_W-1:0] v0,
                                            logic signed [IN_W-1:0] v1);
    logic signed [ACC_W-1:0] h;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    axis_coef_t c;
    h = (ACC_W'(p1) - ACC_W'(p0)) * 40'sd1000;
    a = ACC_W'(v0) * DUR;
    b = ACC_W'(v1) * DUR;
    c.c0 = ACC_W'(p0) * 40'sd1000;
    c.c1 = a;
    c.c3 = h * 40'sd10 - a * 40'sd6 - b * 40'sd4;
    c.c4 = a * 40'sd8 + b * 40'sd7 - h * 40'sd15;
    c.c5 = h * 40'sd6 - a * 40'sd3 - b * 40'sd3;
    c.d2 = h * 40'sd30 - a * 40'sd18 - b * 40'sd12;
    c.d3 = a * 40'sd32 + b * 40'sd28 - h * 40'sd60;
    c.d4 = h * 40'sd30 - a * 40'sd15 - b * 40'sd15;
    return c;
  endfunction

  // Register writes; every index of the port names a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_vel_x <= 16'sd1280;
      end_vel_x   <= 16'sd1280;
      start_vel_y <= '0;
      end_vel_y   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_VEL_X: start_vel_x <= cfg_data;
        REG_END_VEL_X:   end_vel_x   <= cfg_data;
        REG_START_VEL_Y: start_vel_y <= cfg_data;
        REG_END_VEL_Y:   end_vel_y   <= cfg_data;
        default:         start_vel_x <= start_vel_x;
      endcase
    end
  end

  // A beat is taken whenever the queue has room.
  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    push_data.x = solve_axis(start_x, end_x, start_vel_x, end_vel_x);
    push_data.y = solve_axis(start_y, end_y, start_vel_y, end_vel_y);
  end

endmodule

FILE: hw/rtl/qts_fifo.sv
// Short queue of solved coefficient sets between front and back.
// Depends on qts_pkg.
`timescale 1ns / 1ps
module qts_fifo import qts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  coef_set_t push_data,
  input  logic      pop,
  output coef_set_t pop_data,
  output logic      empty,
  output logic      full
);

  coef_set_t          mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign empty    = (count == '0);
  assign full     = (count == (QPTR_W+1)'(QDEPTH));
  assign pop_data = mem[rd_ptr];

  // Storage is written only on push.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/qts_div.sv
// Floor division by a constant with rounding bias and saturation.
// Depends on qts_pkg; the quotient comes from a reciprocal multiply over three stages.
`timescale 1ns / 1ps
module qts_div import qts_pkg::*; #(
  parameter int DIVISOR = 1000,
  parameter int HALF    = 500
) (
  input  logic                    clk,
  input  logic signed [ACC_W-1:0] num,
  output logic signed [OUT_W-1:0] quo
);

  localparam int HW     = ACC_W / 2;
  localparam int SHIFT  = ACC_W + $clog2(DIVISOR);
  localparam int PROD_W = 2 * ACC_W + 1;

  localparam logic signed [ACC_W+1:0] BIAS =
      (ACC_W+2)'(HALF) + ((ACC_W+2)'(DIVISOR) <<< (OUT_W-1));
  localparam logic signed [ACC_W+1:0] LIMIT = (ACC_W+2)'(DIVISOR) <<< OUT_W;

  // Rounded-up reciprocal; exact for every numerator below two to the ACC_W.
  localparam logic [63:0] RECIP64 =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [ACC_W:0]    RECIP    = RECIP64[ACC_W:0];
  localparam logic [ACC_W-HW:0] RECIP_HI = RECIP[ACC_W:HW];
  localparam logic [HW-1:0]     RECIP_LO = RECIP[HW-1:0];

  logic signed [ACC_W+1:0] biased;
  logic [ACC_W-1:0]        num_u;
  logic                    under1;
  logic                    over1;
  logic [2*HW:0]           pp_hh;
  logic [2*HW-1:0]         pp_hl;
  logic [2*HW:0]           pp_lh;
  logic [2*HW-1:0]         pp_ll;
  logic                    under2;
  logic                    over2;
  logic [PROD_W-1:0]       prod;
  logic                    under3;
  logic                    over3;
  logic [OUT_W-1:0]        q;

  // Shift the numerator so that the quotient is never negative in range.
  assign biased = (ACC_W+2)'(num) + BIAS;

  always_ff @(posedge clk) begin
    num_u  <= biased[ACC_W-1:0];
    under1 <= (biased < 0);
    over1  <= (biased >= LIMIT);
  end

  // Partial products of the numerator and the reciprocal.
  always_ff @(posedge clk) begin
    pp_hh  <= num_u[ACC_W-1:HW] * RECIP_HI;
    pp_hl  <= num_u[ACC_W-1:HW] * RECIP_LO;
    pp_lh  <= num_u[HW-1:0] * RECIP_HI;
    pp_ll  <= num_u[HW-1:0] * RECIP_LO;
    under2 <= under1;
    over2  <= over1;
  end

  // Combine the partial products into the full product.
  always_ff @(posedge clk) begin
    prod   <= (PROD_W'(pp_hh) << (2*HW))
              + ((PROD_W'(pp_hl) + PROD_W'(pp_lh)) << HW)
              + PROD_W'(pp_ll);
    under3 <= under2;
    over3  <= over2;
  end

  assign q = prod[SHIFT +: OUT_W];

  // Remove the bias and clamp to the output range.
  always_comb begin
    if (under3) begin
      quo = OUT_MIN;
    end else if (over3) begin
      quo = OUT_MAX;
    end else begin
      quo = {~q[OUT_W-1], q[OUT_W-2:0]};
    end
  end

endmodule

FILE: hw/rtl/qts_back.sv
// Back end: sample sequencer, pipelined Horner evaluation and output divide.
// Depends on qts_pkg and qts_div.
`timescale 1ns / 1ps
module qts_back import qts_pkg::*; #(
  parameter int STEPS       = 60,
  parameter int DURATION_MS = 3000
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  coef_set_t                q_data,
  output logic                     pop,
  output logic                     result_valid,
  output logic signed [OUT_W-1:0]  pos_x,
  output logic signed [OUT_W-1:0]  pos_y,
  output logic signed [OUT_W-1:0]  vel_x,
  output logic signed [OUT_W-1:0]  vel_y,
  output logic [IDX_W-1:0]         sample_index,
  output logic                     last
);

  localparam logic [SQ_W-1:0]  SQ_STEP  = SQ_W'((1 << FRAC_W) / STEPS);
  localparam logic [IDX_W-1:0] REM_STEP = IDX_W'((1 << FRAC_W) % STEPS);
  localparam logic [IDX_W-1:0] REM_INIT = IDX_W'(STEPS / 2);
  localparam logic [IDX_W:0]   REM_LIM  = (IDX_W+1)'(STEPS);

  typedef struct packed {
    coef_set_t        c;
    logic [SQ_W-1:0]  sq;
    logic [IDX_W-1:0] k;
    logic             fin;
  } side_t;

  logic             active;
  logic [IDX_W-1:0] k;
  logic [SQ_W-1:0]  sq;
  logic [IDX_W-1:0] rem;
  coef_set_t        cur;
  logic             issue_last;
  logic [IDX_W:0]   rem_sum;
  logic [SQ_W-1:0]  sq_next;
  logic [IDX_W-1:0] rem_next;

  side_t                   sside [0:NSTEP];
  logic                    svld  [0:NSTEP];
  logic signed [ACC_W-1:0] sacc  [0:NSTEP][0:3];
  side_t                   mside [1:NSTEP];
  logic                    mvld  [1:NSTEP];
  logic signed [ACC_W+5:0] mph   [1:NSTEP][0:3];
  logic [ACC_W+4:0]        mpl   [1:NSTEP][0:3];
  logic signed [ACC_W-1:0] macc  [1:NSTEP][0:3];

  logic                    dvld  [0:DIV_LAT-1];
  logic [IDX_W-1:0]        dk    [0:DIV_LAT-1];
  logic                    dfin  [0:DIV_LAT-1];
  logic signed [OUT_W-1:0] quo   [0:3];

  // One Horner step after the split multiply: round, rescale and add.
  function automatic logic signed [ACC_W-1:0] horner_add(logic signed [ACC_W+5:0] ph,
                                                         logic [ACC_W+4:0] pl,
                                                         logic signed [ACC_W-1:0] addend);
    logic signed [ACC_W+25:0] t;
    t = ((ACC_W+26)'(ph) <<< 20) + $signed((ACC_W+26)'(pl))
        + $signed((ACC_W+26)'(1 << (FRAC_W - 1)));
    return $signed(t[ACC_W+FRAC_W-1:FRAC_W]) + addend;
  endfunction

  // Coefficient added after each step, for position or velocity.
  function automatic logic signed [ACC_W-1:0] pick_add(int step, bit vel, axis_coef_t a);
    logic signed [ACC_W-1:0] r;
    unique case (step)
      1:       r = vel ? a.d3 : a.c4;
      2:       r = vel ? a.d2 : a.c3;
      4:       r = a.c1;
      5:       r = a.c0;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Normalized time advances by STEPS-th parts of one, rounded.
  assign issue_last = active && (k == IDX_W'(STEPS));
  assign pop        = (!active || issue_last) && !q_empty;
  assign rem_sum    = {1'b0, rem} + {1'b0, REM_STEP};

  always_comb begin
    if (rem_sum >= REM_LIM) begin
      rem_next = IDX_W'(rem_sum - REM_LIM);
      sq_next  = sq + SQ_STEP + SQ_W'(1);
    end else begin
      rem_next = IDX_W'(rem_sum);
      sq_next  = sq + SQ_STEP;
    end
  end

  // Sample sequencer: one sample a cycle, next item right after the last if one is queued.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k      <= '0;
      sq     <= '0;
      rem    <= '0;
    end else if (pop) begin
      active <= 1'b1;
      k      <= '0;
      sq     <= '0;
      rem    <= REM_INIT;
    end else if (issue_last) begin
      active <= 1'b0;
    end else if (active) begin
      k      <= k + IDX_W'(1);
      sq     <= sq_next;
      rem    <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  // Pipeline head: Horner starts from the leading coefficients.
  always_comb begin
    sside[0].c   = cur;
    sside[0].sq  = sq;
    sside[0].k   = k;
    sside[0].fin = issue_last;
    svld[0]      = active;
    sacc[0][0]   = cur.x.c5;
    sacc[0][1]   = cur.y.c5;
    sacc[0][2]   = cur.x.d4;
    sacc[0][3]   = cur.y.d4;
  end

  // Five Horner steps, each a multiply stage and an add stage.
  for (genvar s = 1; s <= NSTEP; s++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        mvld[s] <= 1'b0;
        svld[s] <= 1'b0;
      end else begin
        mvld[s] <= svld[s-1];
        svld[s] <= mvld[s];
      end
    end

    always_ff @(posedge clk) begin
      mside[s] <= sside[s-1];
      sside[s] <= mside[s];
    end

    for (genvar ch = 0; ch < 4; ch++) begin : g_ch
      localparam bit IS_VEL = (ch >= 2);
      localparam bit IS_Y   = ((ch % 2) == 1);

      always_ff @(posedge clk) begin
        mph[s][ch]  <= $signed(sacc[s-1][ch][ACC_W-1:20])
                       * $signed({1'b0, sside[s-1].sq});
        mpl[s][ch]  <= sacc[s-1][ch][19:0] * sside[s-1].sq;
        macc[s][ch] <= sacc[s-1][ch];
      end

      if (IS_VEL && s == NSTEP) begin : g_pass
        // Velocity has one step fewer; it only keeps pace here.
        always_ff @(posedge clk) begin
          sacc[s][ch] <= macc[s][ch];
        end
      end else begin : g_add
        always_ff @(posedge clk) begin
          sacc[s][ch] <= horner_add(mph[s][ch], mpl[s][ch],
                                    pick_add(s, IS_VEL, IS_Y ? mside[s].c.y
                                                             : mside[s].c.x));
        end
      end
    end
  end

  // Scale to output units: positions by 1000, velocities by the duration.
  qts_div #(.DIVISOR(1000), .HALF(500)) u_div_px (
    .clk (clk), .num (sacc[NSTEP][0]), .quo (quo[0]));
  qts_div #(.DIVISOR(1000), .HALF(500)) u_div_py (
    .clk (clk), .num (sacc[NSTEP][1]), .quo (quo[1]));
  qts_div #(.DIVISOR(DURATION_MS), .HALF(DURATION_MS / 2)) u_div_vx (
    .clk (clk), .num (sacc[NSTEP][2]), .quo (quo[2]));
  qts_div #(.DIVISOR(DURATION_MS), .HALF(DURATION_MS / 2)) u_div_vy (
    .clk (clk), .num (sacc[NSTEP][3]), .quo (quo[3]));

  // Sample index and final flag follow the dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dvld[i] <= 1'b0;
      end
    end else begin
      dvld[0] <= svld[NSTEP];
      for (int i = 1; i < DIV_LAT; i++) begin
        dvld[i] <= dvld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dk[0]   <= sside[NSTEP].k;
    dfin[0] <= sside[NSTEP].fin;
    for (int i = 1; i < DIV_LAT; i++) begin
      dk[i]   <= dk[i-1];
      dfin[i] <= dfin[i-1];
    end
  end

  // Output register; each result beat stands for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= dvld[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    pos_x        <= quo[0];
    pos_y        <= quo[1];
    vel_x        <= quo[2];
    vel_y        <= quo[3];
    sample_index <= dk[DIV_LAT-1];
    last         <= dfin[DIV_LAT-1];
  end

endmodule

FILE: hw/rtl/quintic_trajectory_sampler.sv
// Quintic trajectory sampler top level. One result per cycle within an item; each item gives
// STEPS+1 results, and the sample sequencer in the back end takes the next queued item right
// after the last. A two-entry queue holds solved items. busy is high while that queue is full.
// The receiver cannot stall results.
// Synchronous active-high reset clears the registers to their reset values and empties the pipe.
`timescale 1ns / 1ps
`include "quintic_trajectory_sampler_assert.svh"
module quintic_trajectory_sampler import qts_pkg::*; #(
  parameter int STEPS       = 60,
  parameter int DURATION_MS = 3000
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_index,
  input  logic [IN_W-1:0]         cfg_data,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  start_x,
  input  logic signed [IN_W-1:0]  start_y,
  input  logic signed [IN_W-1:0]  end_x,
  input  logic signed [IN_W-1:0]  end_y,
  output logic                    result_valid,
  output logic signed [OUT_W-1:0] pos_x,
  output logic signed [OUT_W-1:0] pos_y,
  output logic signed [OUT_W-1:0] vel_x,
  output logic signed [OUT_W-1:0] vel_y,
  output logic [IDX_W-1:0]        sample_index,
  output logic                    last
);

  logic      push;
  coef_set_t push_data;
  logic      pop;
  coef_set_t pop_data;
  logic      q_empty;
  logic      q_full;

  // Front end: accept and solve.
  qts_front #(.DURATION_MS(DURATION_MS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  // Queue between the two halves.
  qts_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back end: sample and evaluate.
  qts_back #(.STEPS(STEPS), .DURATION_MS(DURATION_MS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (pop_data),
    .pop          (pop),
    .result_valid (result_valid),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .sample_index (sample_index),
    .last         (last)
  );

  // The final beat of a trajectory carries the top index.
  `QTS_ASSERT_IMPL(last_at_final_index, clk, rst, result_valid && last, sample_index == IDX_W'(STEPS))
  // Beats of one trajectory come back to back with rising index.
  `QTS_ASSERT_NEXT(samples_contiguous, clk, rst, result_valid && !last, result_valid && (sample_index == $past(sample_index) + IDX_W'(1)))
  // A trajectory always begins at index zero.
  `QTS_ASSERT_IMPL(first_index_zero, clk, rst, result_valid && (!$past(result_valid) || $past(last)), sample_index == '0)

endmodule

FILE: bench/tb_quintic_trajectory_sampler.sv
// Self-checking testbench for the quintic trajectory sampler.
// Depends on qts_pkg and the quintic_trajectory_sampler RTL only.
`timescale 1ns / 1ps
module tb_quintic_trajectory_sampler;
  import qts_pkg::*;

  localparam int STEPS = 60;
  localparam int DURATION_MS = 3000;
  localparam int DRAIN = 80;

  typedef struct {
    logic signed [OUT_W-1:0] px;
    logic signed [OUT_W-1:0] py;
    logic signed [OUT_W-1:0] vx;
    logic signed [OUT_W-1:0] vy;
    logic [IDX_W-1:0]        idx;
    logic                    lst;
  } sample_t;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    bit                 flat;
  } point_pair_t;

  logic clk, rst;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [IN_W-1:0] cfg_data;
  logic start, busy;
  logic signed [IN_W-1:0] start_x, start_y, end_x, end_y;
  logic result_valid;
  logic signed [OUT_W-1:0] pos_x, pos_y, vel_x, vel_y;
  logic [IDX_W-1:0] sample_index;
  logic last;

  // Velocity registers as the block should hold them.
  logic signed [15:0] vel_reg [4];

  sample_t pending_samples [$];
  int errors = 0;
  int beats_sent = 0;
  int samples_seen = 0;

  quintic_trajectory_sampler #(.STEPS(STEPS), .DURATION_MS(DURATION_MS)) uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout at %0t with %0d samples pending", $time, pending_samples.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp24(longint v);
    if (v > 64'sd8388607) return OUT_MAX;
    if (v < -64'sd8388608) return OUT_MIN;
    return v[OUT_W-1:0];
  endfunction

  // Horner evaluation with rounding after each multiply by s.
  function automatic longint horner_eval(longint c [6], int n, longint sq);
    longint acc;
    acc = c[n-1];
    for (int i = n - 2; i >= 0; i--)
      acc = floor_div(acc * sq + (64'sd1 <<< (FRAC_W - 1)), 64'sd1 <<< FRAC_W) + c[i];
    return acc;
  endfunction

  // Closed-form quintic coefficients, zero boundary acceleration.
  function automatic void fit_axis(longint p0, longint p1, longint v0, longint v1,
                                   output longint c [6]);
    longint h, a, b;
    h = (p1 - p0) * 1000;
    a = v0 * DURATION_MS;
    b = v1 * DURATION_MS;
    c[0] = p0 * 1000;
    c[1] = a;
    c[2] = 0;
    c[3] = 10 * h - 6 * a - 4 * b;
    c[4] = -15 * h + 8 * a + 7 * b;
    c[5] = 6 * h - 3 * a - 3 * b;
  endfunction

  function automatic void sample_axis(longint c [6], longint sq,
                                      output logic signed [OUT_W-1:0] p,
                                      output logic signed [OUT_W-1:0] v);
    longint d [6];
    for (int i = 0; i < 5; i++) d[i] = (i + 1) * c[i+1];
    d[5] = 0;
    p = clamp24(floor_div(horner_eval(c, 6, sq) + 500, 1000));
    v = clamp24(floor_div(horner_eval(d, 5, sq) + DURATION_MS / 2, DURATION_MS));
  endfunction

  // Queue every sample of one trajectory.
  task automatic predict_trajectory(point_pair_t pp);
    longint cx [6], cy [6];
    longint sq;
    sample_t s;
    fit_axis(pp.sx, pp.ex, vel_reg[REG_START_VEL_X], vel_reg[REG_END_VEL_X], cx);
    fit_axis(pp.sy, pp.ey, vel_reg[REG_START_VEL_Y], vel_reg[REG_END_VEL_Y], cy);
    for (int k = 0; k <= STEPS; k++) begin
      sq = (longint'(k) * (64'sd1 <<< FRAC_W) + STEPS / 2) / STEPS;
      sample_axis(cx, sq, s.px, s.vx);
      sample_axis(cy, sq, s.py, s.vy);
      s.idx = IDX_W'(k);
      s.lst = (k == STEPS);
      pending_samples.insert(pending_samples.size(), s);
    end
  endtask

  // Drive one register write; the caller drops the write enable after the last one.
  task automatic write_reg(cfg_reg_t r, logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    vel_reg[r] = v;
  endtask

  // Send one beat; idle_pct is the chance of a gap before it.
  task automatic send_pair(point_pair_t pp, int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    start   <= 1'b1;
    start_x <= pp.sx;
    start_y <= pp.sy;
    end_x   <= pp.ex;
    end_y   <= pp.ey;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    if (pp.flat) begin
      // Standing still: position holds, velocity is zero.
      for (int k = 0; k <= STEPS; k++)
        pending_samples.insert(pending_samples.size(),
                               sample_t'{pp.sx, pp.sy, '0, '0, IDX_W'(k), k == STEPS});
    end else begin
      predict_trajectory(pp);
    end
  endtask

  // Stop sending and let the pipe empty before any register write.
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic point_pair_t random_pair();
    point_pair_t pp;
    if ($urandom_range(3) == 0) begin
      pp.sx = $signed(16'($urandom_range(0, 511)) - 16'd256);
      pp.sy = $signed(16'($urandom_range(0, 511)) - 16'd256);
      pp.ex = $signed(16'($urandom_range(0, 511)) - 16'd256);
      pp.ey = $signed(16'($urandom_range(0, 511)) - 16'd256);
    end else begin
      pp.sx = 16'($urandom);
      pp.sy = 16'($urandom);
      pp.ex = 16'($urandom);
      pp.ey = 16'($urandom);
    end
    pp.flat = 1'b0;
    return pp;
  endfunction

  // Compare every result beat against the oldest expected sample.
  always @(posedge clk) begin
    sample_t e;
    if (!rst && result_valid) begin
      samples_seen++;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample idx=%0d", $time, sample_index);
        errors++;
      end else begin
        e = pending_samples.pop_front();
        if (pos_x !== e.px || pos_y !== e.py || vel_x !== e.vx || vel_y !== e.vy ||
            sample_index !== e.idx || last !== e.lst) begin
          $display("%0t: expected pos %0d,%0d vel %0d,%0d idx %0d last %0b", $time,
                   e.px, e.py, e.vx, e.vy, e.idx, e.lst);
          $display("%0t: actual   pos %0d,%0d vel %0d,%0d idx %0d last %0b", $time,
                   pos_x, pos_y, vel_x, vel_y, sample_index, last);
          errors++;
        end
      end
    end
  end

  point_pair_t directed_rows [] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1},
    '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b1},
    '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b1},
    '{16'sh5555, -16'sh5556, 16'sh5555, -16'sh5556, 1'b1},
    '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b0},
    '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0},
    '{16'sh5555, -16'sh5556, -16'sh5556, 16'sh5555, 1'b0},
    '{16'sd0, 16'sd0, 16'sd256, -16'sd256, 1'b0},
    '{16'sd1, -16'sd1, -16'sd1, 16'sd1, 1'b0},
    '{16'sd1000, 16'sd2000, 16'sd3000, -16'sd4000, 1'b0}
  };

  initial begin
    int idle_pct [4] = '{0, 71, 0, 36};
    logic [15:0] extremes [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_START_VEL_X;
    cfg_data = '0;
    start = 1'b0;
    start_x = '0;
    start_y = '0;
    end_x = '0;
    end_y = '0;
    vel_reg = '{16'sd1280, 16'sd1280, 16'sd0, 16'sd0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset velocities first.
    repeat (3) send_pair(random_pair(), 0);
    drain_pipe();

    // Directed table with the vehicle at rest at both ends.
    for (int r = 0; r < 4; r++) write_reg(cfg_reg_t'(r), 16'h0000);
    cfg_wr_en <= 1'b0;
    foreach (directed_rows[i]) send_pair(directed_rows[i], 0);
    drain_pipe();

    // Extreme register values: full-scale x velocities of opposite sign, zero and minus one on y.
    for (int r = 0; r < 4; r++) write_reg(cfg_reg_t'(r), extremes[r]);
    cfg_wr_en <= 1'b0;
    repeat (4) send_pair(random_pair(), 0);
    drain_pipe();

    // Random phases, each with its own velocity setting and an idle chance taken from idle_pct.
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 4; r++)
        write_reg(cfg_reg_t'(r), ($urandom_range(2) == 0) ? 16'($urandom)
                                 : 16'($urandom_range(0, 2047)) - 16'd1024);
      cfg_wr_en <= 1'b0;
      repeat (39) send_pair(random_pair(), idle_pct[ph % 4]);
      drain_pipe();
    end

    $display("Sent %0d trajectories over 11 velocity settings and checked %0d samples,",
             beats_sent, samples_seen);
    $display("including full-scale velocities, standing still and random idle gaps.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
